// ===== rtl/core/esu_pkg.sv =====
// esu_pkg: shared types, constants and helpers for the expansion sound unit
// depends on nothing; used by the bus and mix interfaces and every module of the block
package esu_pkg;

	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int VOL_W    = 4;
	localparam int SAW_W    = 5;
	localparam int MIX_W    = 6;
	localparam int PERIOD_W = 12;
	localparam int CNT_W    = PERIOD_W + 1;

	// item kinds
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// address decode
	localparam logic [ADDR_W-1:0] KEY_MASK = 16'hF003;
	localparam logic [ADDR_W-1:0] KEY_HALT = 16'h9003;
	localparam logic [3:0] PAGE_P1  = 4'h9;
	localparam logic [3:0] PAGE_P2  = 4'hA;
	localparam logic [3:0] PAGE_SAW = 4'hB;

	// register select within a channel
	localparam logic [1:0] REG_CTRL = 2'd0;
	localparam logic [1:0] REG_PLO  = 2'd1;
	localparam logic [1:0] REG_PHI  = 2'd2;
	localparam logic [1:0] REG_HALT = 2'd3;

	// period shift amounts
	localparam logic [3:0] SHIFT_0 = 4'd0;
	localparam logic [3:0] SHIFT_4 = 4'd4;
	localparam logic [3:0] SHIFT_8 = 4'd8;

	localparam logic [3:0] SAW_LAST_PHASE = 4'd13;

	typedef struct packed {
		logic              wr;
		logic [1:0]        sel;
		logic [DATA_W-1:0] data;
		logic              tick;
		logic [3:0]        shift;
	} esu_ctl_t;

	function automatic logic [CNT_W-1:0] reload_value(input logic [PERIOD_W-1:0] period,
		input logic [3:0] shift);
		logic [PERIOD_W-1:0] s;
		s = period >> shift;
		return {1'b0, s} + CNT_W'(1);
	endfunction

endpackage

// ===== rtl/core/esu_in_if.sv =====
// esu_in_if: input channel carrying bus writes and clock ticks
// depends on esu_pkg
interface esu_in_if;
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [esu_pkg::ADDR_W-1:0]   bus_addr;
	logic [esu_pkg::DATA_W-1:0]   bus_data;

	modport source (output valid, output cmd, output bus_addr, output bus_data, input ready);
	modport sink (input valid, input cmd, input bus_addr, input bus_data, output ready);
endinterface

// ===== rtl/core/esu_out_if.sv =====
// esu_out_if: result channel carrying the mixed level
// depends on esu_pkg
interface esu_out_if;
	logic                         valid;
	logic                         ready;
	logic [esu_pkg::MIX_W-1:0]    mix_level;

	modport source (output valid, output mix_level, input ready);
	modport sink (input valid, input mix_level, output ready);
endinterface

// ===== rtl/core/esu_cfg_if.sv =====
// esu_cfg_if: configuration write channel for the address line swap
// no dependencies
interface esu_cfg_if;
	logic valid;
	logic ready;
	logic swap_lines;

	modport source (output valid, output swap_lines, input ready);
	modport sink (input valid, input swap_lines, output ready);
endinterface

// ===== rtl/core/esu_pulse.sv =====
// esu_pulse: one pulse channel, register file, timer and duty sequencer
// depends on esu_pkg
module esu_pulse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  esu_pkg::esu_ctl_t         ctl,
	output logic [esu_pkg::VOL_W-1:0] level
);
	import esu_pkg::*;

	logic [VOL_W-1:0]    vol_q;
	logic [2:0]          duty_q;
	logic                ign_q;
	logic [PERIOD_W-1:0] period_q;
	logic                on_q;
	logic [3:0]          phase_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [CNT_W-1:0]    cnt_dec;
	logic [CNT_W-1:0]    cnt_nxt;
	logic [3:0]          phase_nxt;
	logic                advance;

	always_comb begin
		advance   = ctl.tick && on_q;
		cnt_dec   = cnt_q - CNT_W'(1);
		cnt_nxt   = cnt_q;
		phase_nxt = phase_q;
		if (advance) begin
			if (cnt_dec == '0) begin
				cnt_nxt   = reload_value(period_q, ctl.shift);
				phase_nxt = phase_q + 4'd1;
			end else begin
				cnt_nxt = cnt_dec;
			end
		end
		// level after the tick
		if (on_q && (ign_q || phase_nxt <= {1'b0, duty_q}))
			level = vol_q;
		else
			level = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q    <= '0;
			duty_q   <= '0;
			ign_q    <= 1'b0;
			period_q <= '0;
			on_q     <= 1'b0;
			phase_q  <= '0;
			cnt_q    <= CNT_W'(1);
		end else if (ctl.wr) begin
			unique case (ctl.sel)
				REG_CTRL: begin
					vol_q  <= ctl.data[3:0];
					duty_q <= ctl.data[6:4];
					ign_q  <= ctl.data[7];
				end
				REG_PLO: period_q[7:0] <= ctl.data;
				REG_PHI: begin
					period_q[11:8] <= ctl.data[3:0];
					on_q           <= ctl.data[7];
					if (!ctl.data[7])
						phase_q <= '0;
				end
				default: ;
			endcase
		end else begin
			cnt_q   <= cnt_nxt;
			phase_q <= phase_nxt;
		end
	end

endmodule

// ===== rtl/core/esu_saw.sv =====
// esu_saw: sawtooth channel, register file, timer and accumulator
// depends on esu_pkg
module esu_saw (
	input  logic                      clk,
	input  logic                      arst_n,
	input  esu_pkg::esu_ctl_t         ctl,
	output logic [esu_pkg::SAW_W-1:0] level
);
	import esu_pkg::*;

	logic [5:0]          rate_q;
	logic [PERIOD_W-1:0] period_q;
	logic                on_q;
	logic [3:0]          phase_q;
	logic [7:0]          accum_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [CNT_W-1:0]    cnt_dec;
	logic [CNT_W-1:0]    cnt_nxt;
	logic [3:0]          phase_nxt;
	logic [7:0]          accum_nxt;

	always_comb begin
		cnt_dec   = cnt_q - CNT_W'(1);
		cnt_nxt   = cnt_q;
		phase_nxt = phase_q;
		accum_nxt = accum_q;
		if (ctl.tick && on_q) begin
			if (cnt_dec == '0) begin
				cnt_nxt   = reload_value(period_q, ctl.shift);
				phase_nxt = (phase_q == SAW_LAST_PHASE) ? 4'd0 : phase_q + 4'd1;
				if (phase_nxt == 4'd0)
					accum_nxt = '0;
				else if (!phase_nxt[0])
					accum_nxt = accum_q + {2'b00, rate_q};
			end else begin
				cnt_nxt = cnt_dec;
			end
		end
		level = on_q ? accum_nxt[7:3] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= '0;
			period_q <= '0;
			on_q     <= 1'b0;
			phase_q  <= '0;
			accum_q  <= '0;
			cnt_q    <= CNT_W'(1);
		end else if (ctl.wr) begin
			unique case (ctl.sel)
				REG_CTRL: rate_q <= ctl.data[5:0];
				REG_PLO:  period_q[7:0] <= ctl.data;
				REG_PHI: begin
					period_q[11:8] <= ctl.data[3:0];
					on_q           <= ctl.data[7];
					if (!ctl.data[7]) begin
						phase_q <= '0;
						accum_q <= '0;
					end
				end
				default: ;
			endcase
		end else begin
			cnt_q   <= cnt_nxt;
			phase_q <= phase_nxt;
			accum_q <= accum_nxt;
		end
	end

endmodule

// ===== rtl/core/expansion_sound_unit_core.sv =====
// expansion_sound_unit_core: top level, input register, write decode and level mix
// depends on esu_pkg, esu_in_if, esu_out_if, esu_cfg_if, esu_pulse, esu_saw
//
// usage
//  bus: one item per handshake, either a cpu bus write (cmd 0) or one clock tick (cmd 1)
//  mix: one item per tick carrying the summed level of both pulses and the saw, 0 to 61
//  cfg: writes swap_lines; always ready; the user must write it only while the block
//  is idle, which the block does not enforce; a write item gives no result; it lands
//  in the channel registers in the cycle after acceptance
//  a tick's level reaches mix through the input register, then the result register
//  throughput: one item per cycle while no tick waits on a stalled mix, set by the
//  single pass from input register to the channel state and result register
//  reset clears all channel state, halt and shift; countdowns restart at one
//  when mix stalls, a waiting tick holds in the input register and bus ready drops;
//  write items still pass while the result waits
module expansion_sound_unit_core (
	input  logic       clk,
	input  logic       arst_n,
	esu_in_if.sink     bus,
	esu_out_if.source  mix,
	esu_cfg_if.sink    cfg
);
	import esu_pkg::*;

	logic              swap_q;
	logic              halted_q;
	logic [3:0]        shift_q;

	logic              v_s1;
	logic              cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] data_s1;

	logic              res_v_q;
	logic [MIX_W-1:0]  res_q;

	logic              fire;
	logic              fire_wr;
	logic [ADDR_W-1:0] addr_sw;
	logic [ADDR_W-1:0] key;
	esu_ctl_t          p1_ctl;
	esu_ctl_t          p2_ctl;
	esu_ctl_t          saw_ctl;
	logic [VOL_W-1:0]  p1_level;
	logic [VOL_W-1:0]  p2_level;
	logic [SAW_W-1:0]  saw_level;
	logic [MIX_W-1:0]  mix_sum;

	assign fire      = v_s1 && (cmd_s1 == CMD_WRITE || !res_v_q || mix.ready);
	assign fire_wr   = fire && cmd_s1 == CMD_WRITE;
	assign bus.ready = !v_s1 || fire;
	assign cfg.ready = 1'b1;

	always_comb begin
		addr_sw = addr_s1;
		if (swap_q)
			addr_sw = {addr_s1[ADDR_W-1:2], addr_s1[0], addr_s1[1]};
		key = addr_sw & KEY_MASK;

		p1_ctl.wr    = 1'b0;
		p1_ctl.sel   = key[1:0];
		p1_ctl.data  = data_s1;
		p1_ctl.tick  = fire && cmd_s1 == CMD_TICK && !halted_q;
		p1_ctl.shift = shift_q;
		p2_ctl       = p1_ctl;
		saw_ctl      = p1_ctl;
		if (fire_wr && key[1:0] != REG_HALT) begin
			p1_ctl.wr  = key[15:12] == PAGE_P1;
			p2_ctl.wr  = key[15:12] == PAGE_P2;
			saw_ctl.wr = key[15:12] == PAGE_SAW;
		end

		mix_sum = MIX_W'(p1_level) + MIX_W'(p2_level) + MIX_W'(saw_level);
	end

	esu_pulse u_pulse1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (p1_ctl),
		.level  (p1_level)
	);

	esu_pulse u_pulse2 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (p2_ctl),
		.level  (p2_level)
	);

	esu_saw u_saw (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (saw_ctl),
		.level  (saw_level)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (bus.ready) begin
			v_s1 <= bus.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bus.ready && bus.valid) begin
			cmd_s1  <= bus.cmd;
			addr_s1 <= bus.bus_addr;
			data_s1 <= bus.bus_data;
		end
	end

	// halt and period shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
			shift_q  <= SHIFT_0;
		end else if (fire_wr && key == KEY_HALT) begin
			halted_q <= data_s1[0];
			if (data_s1[2])
				shift_q <= SHIFT_8;
			else if (data_s1[1])
				shift_q <= SHIFT_4;
			else
				shift_q <= SHIFT_0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			swap_q <= cfg.swap_lines;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (fire && cmd_s1 == CMD_TICK) begin
			res_v_q <= 1'b1;
		end else if (mix.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && cmd_s1 == CMD_TICK)
			res_q <= mix_sum;
	end

	assign mix.valid     = res_v_q;
	assign mix.mix_level = res_q;

endmodule

// ===== sim/esu_level_checker.sv =====
// esu_level_checker: watches the bus, mix and cfg channels of the sound unit,
// predicts the mixed level of every tick item and compares it with the mix channel
// depends on esu_pkg, esu_in_if, esu_out_if, esu_cfg_if
module esu_level_checker (
	input  logic clk,
	input  logic arst_n,
	esu_in_if    bus,
	esu_out_if   mix,
	esu_cfg_if   cfg,
	output int   fail_count,
	output int   pending_levels
);
	import esu_pkg::*;

	logic [MIX_W-1:0] expected_levels[$];

	logic                swap_on;
	logic [VOL_W-1:0]    p_vol[2];
	logic [2:0]          p_duty[2];
	logic                p_ign[2];
	logic [PERIOD_W-1:0] p_period[2];
	logic                p_on[2];
	logic [3:0]          p_phase[2];
	logic [CNT_W-1:0]    p_count[2];
	logic [5:0]          s_rate;
	logic [PERIOD_W-1:0] s_period;
	logic                s_on;
	logic [3:0]          s_phase;
	logic [7:0]          s_accum;
	logic [CNT_W-1:0]    s_count;
	logic                halted;
	logic [3:0]          shift_amt;

	function automatic logic [CNT_W-1:0] next_reload(input logic [PERIOD_W-1:0] period);
		logic [PERIOD_W-1:0] scaled;
		scaled = period >> shift_amt;
		return CNT_W'(scaled) + CNT_W'(1);
	endfunction

	task automatic clear_sound_state();
		for (int ch = 0; ch < 2; ch++) begin
			p_vol[ch] = '0;
			p_duty[ch] = '0;
			p_ign[ch] = 1'b0;
			p_period[ch] = '0;
			p_on[ch] = 1'b0;
			p_phase[ch] = '0;
			p_count[ch] = CNT_W'(1);
		end
		s_rate = '0;
		s_period = '0;
		s_on = 1'b0;
		s_phase = '0;
		s_accum = '0;
		s_count = CNT_W'(1);
		halted = 1'b0;
		shift_amt = SHIFT_0;
	endtask

	task automatic write_pulse(input int ch, input logic [1:0] sel, input logic [7:0] d);
		case (sel)
			REG_CTRL: begin
				p_vol[ch] = d[3:0];
				p_duty[ch] = d[6:4];
				p_ign[ch] = d[7];
			end
			REG_PLO: p_period[ch][7:0] = d;
			REG_PHI: begin
				p_period[ch][11:8] = d[3:0];
				p_on[ch] = d[7];
				if (!d[7])
					p_phase[ch] = '0;
			end
			default: ;
		endcase
	endtask

	task automatic write_saw(input logic [1:0] sel, input logic [7:0] d);
		case (sel)
			REG_CTRL: s_rate = d[5:0];
			REG_PLO: s_period[7:0] = d;
			REG_PHI: begin
				s_period[11:8] = d[3:0];
				s_on = d[7];
				if (!d[7]) begin
					s_accum = '0;
					s_phase = '0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic decode_bus_write(input logic [ADDR_W-1:0] a, input logic [7:0] d);
		logic [ADDR_W-1:0] key;
		key = (swap_on ? {a[15:2], a[0], a[1]} : a) & KEY_MASK;
		if (key == KEY_HALT) begin
			halted = d[0];
			shift_amt = d[2] ? SHIFT_8 : (d[1] ? SHIFT_4 : SHIFT_0);
		end else if (key[1:0] != REG_HALT) begin
			if (key[15:12] == PAGE_P1)
				write_pulse(0, key[1:0], d);
			else if (key[15:12] == PAGE_P2)
				write_pulse(1, key[1:0], d);
			else if (key[15:12] == PAGE_SAW)
				write_saw(key[1:0], d);
		end
	endtask

	task automatic advance_tick(output logic [MIX_W-1:0] level);
		logic [MIX_W-1:0] sum;
		if (!halted) begin
			for (int ch = 0; ch < 2; ch++) begin
				if (p_on[ch]) begin
					p_count[ch] = p_count[ch] - CNT_W'(1);
					if (p_count[ch] == '0) begin
						p_phase[ch] = p_phase[ch] + 4'd1;
						p_count[ch] = next_reload(p_period[ch]);
					end
				end
			end
			if (s_on) begin
				s_count = s_count - CNT_W'(1);
				if (s_count == '0) begin
					s_phase = (s_phase == SAW_LAST_PHASE) ? 4'd0 : s_phase + 4'd1;
					s_count = next_reload(s_period);
					if (s_phase == 4'd0)
						s_accum = '0;
					else if (!s_phase[0])
						s_accum = s_accum + {2'b00, s_rate};
				end
			end
		end
		sum = '0;
		for (int ch = 0; ch < 2; ch++)
			if (p_on[ch] && (p_ign[ch] || p_phase[ch] <= {1'b0, p_duty[ch]}))
				sum = sum + MIX_W'(p_vol[ch]);
		if (s_on)
			sum = sum + MIX_W'(s_accum[7:3]);
		level = sum;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [MIX_W-1:0] level;
		if (!arst_n) begin
			clear_sound_state();
			swap_on = 1'b0;
			expected_levels.delete();
			fail_count = 0;
			pending_levels = 0;
		end else begin
			if (mix.valid && mix.ready) begin
				if (expected_levels.size() == 0) begin
					$error("mix item with no tick waiting: mix_level %0d", mix.mix_level);
					fail_count++;
				end else begin
					level = expected_levels.pop_front();
					if (mix.mix_level !== level) begin
						$error("mix_level mismatch: expected %0d, actual %0d",
							level, mix.mix_level);
						fail_count++;
					end
				end
			end
			if (cfg.valid && cfg.ready)
				swap_on = cfg.swap_lines;
			if (bus.valid && bus.ready) begin
				if (bus.cmd == CMD_TICK) begin
					advance_tick(level);
					expected_levels.push_back(level);
				end else begin
					decode_bus_write(bus.bus_addr, bus.bus_data);
				end
			end
			pending_levels = expected_levels.size();
		end
	end

endmodule

// ===== sim/expansion_sound_unit_core_tb.sv =====
// expansion_sound_unit_core_tb: drives bus writes, ticks and swap settings into the
// sound unit with random idling; the level checker predicts and compares
// depends on esu_pkg, the esu interfaces, expansion_sound_unit_core, esu_level_checker
module expansion_sound_unit_core_tb;
	import esu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending_levels;
	int   src_idle_pct = 0;
	int   snk_stall_pct = 0;
	logic swap_now = 1'b0;

	localparam int PHASES = 4;
	localparam int PHASE_ITEMS = 175;
	localparam int SRC_IDLE[PHASES] = '{0, 49, 0, 13};
	localparam int SNK_STALL[PHASES] = '{0, 0, 49, 13};
	localparam logic SWAP_PLAN[PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0};

	esu_in_if  bus_if();
	esu_out_if mix_if();
	esu_cfg_if cfg_if();

	expansion_sound_unit_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.bus    (bus_if),
		.mix    (mix_if),
		.cfg    (cfg_if)
	);

	esu_level_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.bus            (bus_if),
		.mix            (mix_if),
		.cfg            (cfg_if),
		.fail_count     (fail_count),
		.pending_levels (pending_levels)
	);

	always #4 clk = ~clk;

	initial begin
		mix_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			mix_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	task automatic send_item(input logic c, input logic [ADDR_W-1:0] a, input logic [7:0] d);
		while ($urandom_range(99) < src_idle_pct) begin
			bus_if.valid <= 1'b0;
			@(negedge clk);
		end
		bus_if.valid <= 1'b1;
		bus_if.cmd <= c;
		bus_if.bus_addr <= a;
		bus_if.bus_data <= d;
		@(posedge clk);
		while (!bus_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] reg_addr(input logic [3:0] page, input logic [1:0] sel);
		logic [1:0] raw;
		raw = swap_now ? {sel[0], sel[1]} : sel;
		return {page, 10'($urandom), raw};
	endfunction

	task automatic send_random_item();
		int roll;
		logic [3:0] page;
		logic [1:0] sel;
		logic [7:0] d;
		roll = $urandom_range(99);
		d = 8'($urandom);
		if (roll < 55) begin
			send_item(CMD_TICK, 16'($urandom), d);
		end else if (roll < 90) begin
			if ($urandom_range(9) == 0) begin
				if ($urandom_range(99) < 85)
					d[0] = 1'b0;
				send_item(CMD_WRITE, reg_addr(PAGE_P1, REG_HALT), d);
			end else begin
				case ($urandom_range(2))
					0: page = PAGE_P1;
					1: page = PAGE_P2;
					default: page = PAGE_SAW;
				endcase
				case ($urandom_range(2))
					0: sel = REG_CTRL;
					1: sel = REG_PLO;
					default: sel = REG_PHI;
				endcase
				if (sel == REG_PLO && $urandom_range(99) < 70)
					d = 8'($urandom_range(15));
				if (sel == REG_PHI) begin
					if ($urandom_range(99) < 80)
						d[7] = 1'b1;
					if ($urandom_range(99) < 75)
						d[3:0] = 4'd0;
				end
				send_item(CMD_WRITE, reg_addr(page, sel), d);
			end
		end else begin
			send_item(CMD_WRITE, 16'($urandom), d);
		end
	endtask

	task automatic settle();
		bus_if.valid <= 1'b0;
		while (pending_levels != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_swap(input logic v);
		cfg_if.valid <= 1'b1;
		cfg_if.swap_lines <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		swap_now = v;
	endtask

	initial begin
		bus_if.valid = 1'b0;
		bus_if.cmd = CMD_WRITE;
		bus_if.bus_addr = '0;
		bus_if.bus_data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.swap_lines = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, unmapped, halt, shift, disable while counting
		send_item(CMD_TICK, 16'h0000, 8'h00);
		send_item(CMD_WRITE, 16'hFFFF, 8'hFF);
		send_item(CMD_WRITE, 16'h0000, 8'hFF);
		send_item(CMD_TICK, 16'hFFFF, 8'hFF);
		send_item(CMD_WRITE, 16'h9000, 8'hFF);
		send_item(CMD_WRITE, 16'h9001, 8'h00);
		send_item(CMD_WRITE, 16'h9002, 8'h80);
		send_item(CMD_TICK, 16'h0000, 8'h00);
		send_item(CMD_WRITE, 16'hAFFC, 8'h7F);
		send_item(CMD_WRITE, 16'hA001, 8'hFF);
		send_item(CMD_WRITE, 16'hA002, 8'h8F);
		send_item(CMD_WRITE, 16'hB000, 8'hFF);
		send_item(CMD_WRITE, 16'hB001, 8'h00);
		send_item(CMD_WRITE, 16'hB002, 8'h80);
		repeat (8) send_item(CMD_TICK, 16'h0000, 8'h00);
		send_item(CMD_WRITE, 16'h9003, 8'h01);
		send_item(CMD_TICK, 16'h0000, 8'h00);
		send_item(CMD_WRITE, 16'h9003, 8'h04);
		send_item(CMD_WRITE, 16'h9002, 8'h00);
		send_item(CMD_TICK, 16'h0000, 8'h00);
		send_item(CMD_WRITE, 16'h9002, 8'h80);
		send_item(CMD_WRITE, 16'hB002, 8'h0F);
		send_item(CMD_TICK, 16'h0000, 8'h00);
		send_item(CMD_WRITE, 16'h9003, 8'h02);
		send_item(CMD_TICK, 16'h0000, 8'h00);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_swap(SWAP_PLAN[ph]);
			src_idle_pct = SRC_IDLE[ph];
			snk_stall_pct = SNK_STALL[ph];
			repeat (PHASE_ITEMS) send_random_item();
		end
		settle();

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2400000;
		$display("FAIL");
		$finish;
	end

endmodule
